[hdl/zfn_pkg.sv]
// shared types, constants and codes of the z-score normaliser
package zfn_pkg;

	localparam int FEAT_MAX_DEF = 512;
	localparam int SAMP_MAX_DEF = 65536;

	localparam int DIV_DW = 50;
	localparam int ROOT_W = 25;

	localparam logic [1:0] MODE_SUM  = 2'd0;
	localparam logic [1:0] MODE_SQD  = 2'd1;
	localparam logic [1:0] MODE_NORM = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [9:0]  FC_RESET = 10'd256;
	localparam logic [15:0] DEV_ONE  = 16'd256;

	localparam logic [5:0] NB_NORM = 6'd24;
	localparam logic [5:0] NB_MEAN = 6'd32;
	localparam logic [5:0] NB_DEV  = 6'd50;

	typedef struct packed {
		logic [1:0]         mode;
		logic [8:0]         feature_index;
		logic signed [15:0] sample_value;
		logic               end_of_pass;
	} item_t;

	typedef struct packed {
		logic [8:0]         out_index;
		logic signed [15:0] normalized_value;
		logic               saturated;
	} result_t;

endpackage

[hdl/zfn_ram.sv]
// generic single write port ram with registered read
module zfn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[hdl/zfn_divider.sv]
// iterative restoring divider, one quotient bit per cycle
module zfn_divider import zfn_pkg::*; #(
	parameter int VW = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_DW-1:0] dividend,
	input  logic [5:0]        nbits,
	input  logic [VW-1:0]     divisor,
	output logic              busy,
	output logic [DIV_DW-1:0] quotient
);
	logic [DIV_DW-1:0] q_q;
	logic [VW-1:0]     r_q;
	logic [VW-1:0]     d_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [VW:0]       r2;
	logic [VW:0]       diff;
	logic              take;

	// dividend arrives left aligned so the top nbits are the live ones
	assign r2   = {r_q, q_q[DIV_DW-1]};
	assign diff = r2 - {1'b0, d_q};
	assign take = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DIV_DW-2:0], take};
			r_q <= take ? diff[VW-1:0] : r2[VW-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;
endmodule

[hdl/zfn_sqrt.sv]
// digit by digit integer square root, one root bit per cycle
module zfn_sqrt import zfn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_DW-1:0] radicand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);
	logic [DIV_DW-1:0] rad_q;
	logic [ROOT_W+2:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [ROOT_W+2:0] rem2;
	logic [ROOT_W+2:0] trial;
	logic              take;

	assign rem2  = {rem_q[ROOT_W:0], rad_q[DIV_DW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take  = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[DIV_DW-3:0], 2'b00};
			rem_q  <= take ? (rem2 - trial) : rem2;
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

[hdl/zscore_feature_normalizer_core.sv]
// top level of the three pass z-score feature normaliser
// Per-feature z-score standardisation over three passes of one data set, one feature value per
// transfer. Mode 0 adds values into per-feature sums and counts samples; mode 1 adds squared
// deviations from the means; mode 2 returns (value - mean) / deviation in Q7.8, saturated with
// a flag. end_of_pass in mode 0 or 1 walks every feature in use and finalises its mean (sum /
// samples) or its deviation (floor square root of squared sum / samples, 256 when zero). The
// block takes one item at a time and holds item_stall high while it works. A mode-2 item runs
// 24 divider steps; a finalise walk runs a division per feature for a mean, and 50 divider
// steps then 25 root steps per feature for a deviation, on the one shared iterative divider
// and the root unit. After reset a clearing pass over all MAX_FEATURES entries fills the
// tables before the first item; the first mode-0 item after reset or after any other mode
// starts a second pass over all MAX_FEATURES entries that clears the sums, squared sums and
// sample count. The result sits in an output register, so it may wait while the next item
// is taken. feature_count is written through cfg_data at any time the block is idle.
module zscore_feature_normalizer_core import zfn_pkg::*; #(
	parameter int MAX_FEATURES = FEAT_MAX_DEF,
	parameter int MAX_SAMPLES  = SAMP_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [9:0] cfg_data,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);
	localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW = ((AW > 10) ? AW : 10) + 1;
	localparam int SW = $clog2(MAX_SAMPLES + 1);
	localparam int VW = (SW > 16) ? SW : 16;

	// sequencer codes
	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CLRP   = 4'd2;
	localparam logic [3:0] S_RD     = 4'd3;
	localparam logic [3:0] S_EXEC   = 4'd4;
	localparam logic [3:0] S_SQ     = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;
	localparam logic [3:0] S_FRD    = 4'd8;
	localparam logic [3:0] S_FSTART = 4'd9;
	localparam logic [3:0] S_FDIV   = 4'd10;
	localparam logic [3:0] S_FSQ    = 4'd11;
	localparam logic [3:0] S_FWR    = 4'd12;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] samples_q;
	logic [1:0]    prev_mode_q;
	logic [9:0]    fc_q;
	logic          result_valid_q;
	item_t         item_q;
	result_t       result_q;
	logic [15:0]   res_q;
	logic          neg_q;
	logic [31:0]   sq_q;

	logic          accept;
	logic [9:0]    n_use;
	logic          idx_ok;
	logic          idx_last;
	logic [CW-1:0] idx_ext;
	logic [AW-1:0] addr;
	logic          sweep_addr;
	logic          cnt_last_fin;
	logic          cnt_last_clr;
	logic          out_free;

	logic [31:0] sum_rd;
	logic [49:0] sq_rd;
	logic [15:0] mean_rd;
	logic [15:0] dev_rd;
	logic        sum_we, sq_we, mean_we, dev_we;
	logic [31:0] sum_wd;
	logic [49:0] sq_wd;
	logic [15:0] mean_wd, dev_wd;

	logic signed [16:0] d17;
	logic [16:0]        d17_neg;
	logic [15:0]        d_mag;
	logic signed [33:0] prod;
	logic [32:0]        sum33;
	logic [31:0]        sum_sat;
	logic [50:0]        acc51;
	logic [49:0]        acc_sat;
	logic [32:0]        sum_neg33;
	logic [31:0]        sum_mag;
	logic [15:0]        dev_div;

	logic              div_start;
	logic [DIV_DW-1:0] div_dividend;
	logic [5:0]        div_nbits;
	logic [VW-1:0]     div_divisor;
	logic              div_busy;
	logic [DIV_DW-1:0] div_q;
	logic              sqrt_start;
	logic              sqrt_busy;
	logic [ROOT_W-1:0] sqrt_root;

	logic              q_sat;
	logic [15:0]       q_val;
	logic [15:0]       q_neg;
	logic [15:0]       dev_val;

	// config taken only between items
	assign cfg_ready  = (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && (state_q == S_IDLE);
	assign out_free   = !result_valid_q || !result_stall;

	// feature count in use, clamped to 1..MAX_FEATURES
	always_comb begin
		if (fc_q == 10'd0) begin
			n_use = 10'd1;
		end else if (int'(fc_q) > MAX_FEATURES) begin
			n_use = 10'(MAX_FEATURES);
		end else begin
			n_use = fc_q;
		end
	end

	assign idx_ok       = {1'b0, item_q.feature_index} < n_use;
	assign idx_last     = {1'b0, item_q.feature_index} == (n_use - 10'd1);
	assign idx_ext      = CW'(item_q.feature_index);
	assign cnt_last_fin = cnt_q == (CW'(n_use) - CW'(1));
	assign cnt_last_clr = cnt_q == CW'(MAX_FEATURES - 1);

	// sweeps address by counter, item work by feature index
	always_comb begin
		case (state_q)
			S_CLR, S_CLRP, S_FRD, S_FSTART, S_FDIV, S_FSQ, S_FWR: sweep_addr = 1'b1;
			default: sweep_addr = 1'b0;
		endcase
	end
	assign addr = sweep_addr ? cnt_q[AW-1:0] : idx_ext[AW-1:0];

	// per-item arithmetic
	assign d17       = {item_q.sample_value[15], item_q.sample_value} - {mean_rd[15], mean_rd};
	assign d17_neg   = -d17;
	assign d_mag     = d17[16] ? d17_neg[15:0] : d17[15:0];
	assign prod      = d17 * d17;
	assign sum33     = {sum_rd[31], sum_rd} + {{17{item_q.sample_value[15]}}, item_q.sample_value};
	assign sum_sat   = (sum33[32] != sum33[31]) ?
		(sum33[32] ? 32'h8000_0000 : 32'h7fff_ffff) : sum33[31:0];
	assign acc51     = {1'b0, sq_rd} + 51'(sq_q);
	assign acc_sat   = acc51[50] ? {50{1'b1}} : acc51[49:0];
	assign sum_neg33 = -{sum_rd[31], sum_rd};
	assign sum_mag   = sum_rd[31] ? sum_neg33[31:0] : sum_rd;
	assign dev_div   = (dev_rd == 16'd0) ? 16'd1 : dev_rd;

	// signed quotient back from magnitude, saturated to 16 bits
	assign q_neg = -div_q[15:0];
	assign q_sat = neg_q ? (div_q > 50'd32768) : (div_q > 50'd32767);
	assign q_val = q_sat ? (neg_q ? 16'h8000 : 16'h7fff) : (neg_q ? q_neg : div_q[15:0]);

	always_comb begin
		if (sqrt_root > 25'd65535) begin
			dev_val = 16'hffff;
		end else if (sqrt_root == 25'd0) begin
			dev_val = DEV_ONE;
		end else begin
			dev_val = sqrt_root[15:0];
		end
	end

	// shared divider hookup
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {d_mag, 8'h00, 26'd0};
		div_nbits    = NB_NORM;
		div_divisor  = VW'(dev_div);
		if (state_q == S_EXEC) begin
			div_start = (item_q.mode == MODE_NORM) && idx_ok;
		end else if (state_q == S_FSTART) begin
			div_start   = (samples_q != '0);
			div_divisor = VW'(samples_q);
			if (item_q.mode == MODE_SUM) begin
				div_dividend = {sum_mag, 18'd0};
				div_nbits    = NB_MEAN;
			end else begin
				div_dividend = sq_rd;
				div_nbits    = NB_DEV;
			end
		end
	end

	assign sqrt_start = (state_q == S_FDIV) && !div_busy && (item_q.mode == MODE_SQD);

	// table writes
	always_comb begin
		sum_we  = 1'b0;
		sq_we   = 1'b0;
		mean_we = 1'b0;
		dev_we  = 1'b0;
		sum_wd  = sum_sat;
		sq_wd   = acc_sat;
		mean_wd = res_q;
		dev_wd  = res_q;
		case (state_q)
			S_CLR: begin
				sum_we  = 1'b1;
				sq_we   = 1'b1;
				mean_we = 1'b1;
				dev_we  = 1'b1;
				sum_wd  = '0;
				sq_wd   = '0;
				mean_wd = '0;
				dev_wd  = DEV_ONE;
			end
			S_CLRP: begin
				sum_we = 1'b1;
				sq_we  = 1'b1;
				sum_wd = '0;
				sq_wd  = '0;
			end
			S_EXEC: sum_we = (item_q.mode == MODE_SUM) && idx_ok;
			S_SQ:   sq_we  = 1'b1;
			S_FWR: begin
				mean_we = (item_q.mode == MODE_SUM);
				dev_we  = (item_q.mode == MODE_SQD);
			end
			default: ;
		endcase
	end

	zfn_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_sum_ram (
		.clk(clk), .we(sum_we), .waddr(addr), .wdata(sum_wd), .raddr(addr), .rdata(sum_rd)
	);
	zfn_ram #(.WIDTH(50), .DEPTH(MAX_FEATURES)) u_sq_ram (
		.clk(clk), .we(sq_we), .waddr(addr), .wdata(sq_wd), .raddr(addr), .rdata(sq_rd)
	);
	zfn_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_mean_ram (
		.clk(clk), .we(mean_we), .waddr(addr), .wdata(mean_wd), .raddr(addr), .rdata(mean_rd)
	);
	zfn_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_dev_ram (
		.clk(clk), .we(dev_we), .waddr(addr), .wdata(dev_wd), .raddr(addr), .rdata(dev_rd)
	);

	zfn_divider #(.VW(VW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.nbits(div_nbits), .divisor(div_divisor), .busy(div_busy), .quotient(div_q)
	);

	zfn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .radicand(div_q),
		.busy(sqrt_busy), .root(sqrt_root)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			cnt_q          <= '0;
			samples_q      <= '0;
			prev_mode_q    <= MODE_NORM;
			fc_q           <= FC_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fc_q <= cfg_data;
			end
			// result leaves on a transfer unless a new one is loaded
			if (!result_stall && !((state_q == S_OUT) && out_free)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (cnt_last_clr) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_IDLE: begin
					if (accept && (item.mode != MODE_NONE)) begin
						prev_mode_q <= item.mode;
						cnt_q       <= '0;
						// new first pass wipes sums and count
						if ((item.mode == MODE_SUM) && (prev_mode_q != MODE_SUM)) begin
							samples_q <= '0;
							state_q   <= S_CLRP;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CLRP: begin
					if (cnt_last_clr) begin
						cnt_q   <= '0;
						state_q <= S_RD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_RD: state_q <= S_EXEC;
				S_EXEC: begin
					case (item_q.mode)
						MODE_SUM: begin
							if (idx_ok && idx_last && (int'(samples_q) < MAX_SAMPLES)) begin
								samples_q <= samples_q + SW'(1);
							end
							state_q <= item_q.end_of_pass ? S_FRD : S_IDLE;
						end
						MODE_SQD: begin
							if (idx_ok) begin
								state_q <= S_SQ;
							end else begin
								state_q <= item_q.end_of_pass ? S_FRD : S_IDLE;
							end
						end
						default: state_q <= idx_ok ? S_DIV : S_IDLE;
					endcase
				end
				S_SQ:  state_q <= item_q.end_of_pass ? S_FRD : S_IDLE;
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_FRD: state_q <= S_FSTART;
				S_FSTART: state_q <= (samples_q == '0) ? S_FWR : S_FDIV;
				S_FDIV: begin
					if (!div_busy) begin
						state_q <= (item_q.mode == MODE_SUM) ? S_FWR : S_FSQ;
					end
				end
				S_FSQ: begin
					if (!sqrt_busy) begin
						state_q <= S_FWR;
					end
				end
				S_FWR: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_last_fin) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (state_q == S_EXEC) begin
			neg_q <= d17[16];
			sq_q  <= prod[31:0];
		end
		if (state_q == S_FSTART) begin
			neg_q <= sum_rd[31];
			res_q <= (item_q.mode == MODE_SUM) ? 16'd0 : DEV_ONE;
		end
		if ((state_q == S_FDIV) && !div_busy) begin
			res_q <= q_val;
		end
		if ((state_q == S_FSQ) && !sqrt_busy) begin
			res_q <= dev_val;
		end
		if ((state_q == S_OUT) && out_free) begin
			result_q.out_index        <= item_q.feature_index;
			result_q.normalized_value <= q_val;
			result_q.saturated        <= q_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule

[hdl/zfn_checker.sv]
// port level checks for the normaliser, bound to the top level
module zfn_checker import zfn_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);
	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a working item keeps the input closed next cycle
	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (item.mode != MODE_NONE) |=> item_stall)
		else $error("input open right after an item transfer");

	// results only come out of item processing
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without work");
endmodule

bind zscore_feature_normalizer_core zfn_checker u_zfn_checker (.*);
